@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

@@ sv/prbq_pkg.sv @@
// ----------------------------------------------------------------------------
// prbq_pkg
// shared types, codes and helpers of the priority bitmap ready queue
// ----------------------------------------------------------------------------
`default_nettype none

package prbq_pkg;

    localparam int KIND_W    = 2;
    localparam int THREAD_W  = 6;
    localparam int PRIO_W    = 6;

    localparam int DEF_NUM_LEVELS  = 64;
    localparam int DEF_MAX_THREADS = 64;

    localparam logic [KIND_W-1:0] KIND_ADD_ACTIVE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_EXPIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PICK        = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic add_exec;
        logic pick_exec;
        logic pop_exec;
    } prbq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic add_ok;
        logic pick_req;
        logic multi;
    } prbq_sts_t;

    // index of the highest set bit, zero when none is set
    function automatic logic [2:0] top_bit8(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 1; i < 8; i++)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ sv/priority_bitmap_ready_queue_core.sv @@
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue_core
// two-bank scheduler ready queue with fifo lists per level, two-level bitmap
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken at a rising edge with start high and busy low.
//   kind selects add to the active bank, add to the expired bank, or pick.
//   adds give no result; a rejected add (thread already queued, level or
//   thread out of range) and an unknown kind leave busy low.
//   a pick gives one result beat: strobe is high for exactly one cycle with
//   picked_thread, picked_priority, idle and swapped; it comes from the result
//   registers loaded in the pick step. there is no back pressure on results.
// steps:
//   add: accept with the tail read, then the memory and bitmap update.
//   pick: accept, then the pick step; when the picked level holds more
//   than one thread, a pop step follows that uses the link memory to move
//   the list head forward.
// reset:
//   both banks empty, bank 0 active, no thread queued. the list memories
//   need no clearing since they are only read behind a set level bit.
`default_nettype none

module priority_bitmap_ready_queue_core #(
    parameter int NUM_LEVELS  = prbq_pkg::DEF_NUM_LEVELS,
    parameter int MAX_THREADS = prbq_pkg::DEF_MAX_THREADS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [prbq_pkg::KIND_W-1:0]   kind,
    input  logic [prbq_pkg::THREAD_W-1:0] thread_id,
    input  logic [prbq_pkg::PRIO_W-1:0]   priority_req,
    output logic                          strobe,
    output logic [prbq_pkg::THREAD_W-1:0] picked_thread,
    output logic [prbq_pkg::PRIO_W-1:0]   picked_priority,
    output logic                          idle,
    output logic                          swapped
);
    import prbq_pkg::*;

    prbq_cmd_t cmd;
    prbq_sts_t sts;

    prbq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    prbq_datapath #(
        .NUM_LEVELS  (NUM_LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .kind            (kind),
        .thread_id       (thread_id),
        .priority_req    (priority_req),
        .cmd             (cmd),
        .sts             (sts),
        .strobe          (strobe),
        .picked_thread   (picked_thread),
        .picked_priority (picked_priority),
        .idle            (idle),
        .swapped         (swapped)
    );

endmodule

`default_nettype wire

@@ sv/prbq_ram.sv @@
// ----------------------------------------------------------------------------
// prbq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module prbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/prbq_ctrl.sv @@
// ----------------------------------------------------------------------------
// prbq_ctrl
// sequencer: accepts a command, runs the add or pick steps, drives busy
// ----------------------------------------------------------------------------
`default_nettype none

module prbq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  prbq_pkg::prbq_sts_t sts,
    output prbq_pkg::prbq_cmd_t cmd,
    output logic                busy
);
    import prbq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_POP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (sts.add_ok)
                    begin
                        state_next = S_ADD;
                    end
                    else if (sts.pick_req)
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            S_ADD:
            begin
                cmd.add_exec = 1'b1;
                state_next   = S_IDLE;
            end
            S_PICK:
            begin
                cmd.pick_exec = 1'b1;
                // more threads behind the head: advance the head next cycle
                state_next    = sts.multi ? S_POP : S_IDLE;
            end
            S_POP:
            begin
                cmd.pop_exec = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ sv/prbq_datapath.sv @@
// ----------------------------------------------------------------------------
// prbq_datapath
// bitmaps, bank totals, queued flags and the head, tail and link memories
// ----------------------------------------------------------------------------
`default_nettype none

module prbq_datapath #(
    parameter int NUM_LEVELS  = prbq_pkg::DEF_NUM_LEVELS,
    parameter int MAX_THREADS = prbq_pkg::DEF_MAX_THREADS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [prbq_pkg::KIND_W-1:0]   kind,
    input  logic [prbq_pkg::THREAD_W-1:0] thread_id,
    input  logic [prbq_pkg::PRIO_W-1:0]   priority_req,
    input  prbq_pkg::prbq_cmd_t           cmd,
    output prbq_pkg::prbq_sts_t           sts,
    output logic                          strobe,
    output logic [prbq_pkg::THREAD_W-1:0] picked_thread,
    output logic [prbq_pkg::PRIO_W-1:0]   picked_priority,
    output logic                          idle,
    output logic                          swapped
);
    import prbq_pkg::*;

    localparam int TID_SLOTS  = 1 << THREAD_W;
    localparam int TID_DEPTH  = (MAX_THREADS < TID_SLOTS) ? MAX_THREADS : TID_SLOTS;
    localparam int IDXW       = $clog2(TID_DEPTH);
    localparam int CNT_W      = $clog2(TID_DEPTH + 1);
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int LVL_DEPTH  = 1 << LVL_W;
    localparam int NUM_GROUPS = LVL_DEPTH / 8;
    localparam int AW         = LVL_W + 1;

    // bank state
    logic                  active_bank_reg, active_bank_next;
    logic [CNT_W-1:0]      act_total_reg, act_total_next;
    logic [CNT_W-1:0]      exp_total_reg, exp_total_next;
    logic [TID_DEPTH-1:0]  queued_reg, queued_next;
    logic [NUM_GROUPS-1:0] grp_bits_reg [2];
    logic [NUM_GROUPS-1:0] grp_bits_next [2];
    logic [LVL_DEPTH-1:0]  lvl_bits_reg [2];
    logic [LVL_DEPTH-1:0]  lvl_bits_next [2];

    // operation captured at accept
    logic                  op_bank_reg;
    logic [PRIO_W-1:0]     op_lvl_reg;
    logic [IDXW-1:0]       op_tid_reg;
    logic                  op_idle_reg;
    logic                  op_swap_reg;

    // result registers
    logic                  strobe_reg;
    logic [THREAD_W-1:0]   picked_thread_reg;
    logic [PRIO_W-1:0]     picked_priority_reg;
    logic                  idle_reg;
    logic                  swapped_reg;

    // memories
    logic [IDXW-1:0]       head_rdata, tail_rdata, next_rdata;
    logic [IDXW-1:0]       head_wdata;
    logic                  head_we, next_we;
    logic [AW-1:0]         tail_raddr;

    // accept-cycle decode
    logic                  is_add, is_pick, in_range, add_bank;
    logic                  both_empty, do_swap, pk_bank;
    logic [2:0]            pk_grp, pk_bit;
    logic [7:0]            pk_byte;
    logic [PRIO_W-1:0]     pk_lvl;
    logic [AW-1:0]         add_addr, pk_addr, op_addr;

    // execute-cycle helpers
    logic [LVL_W-1:0]      op_li, op_base;
    logic                  add_empty, last_one, grp_empty;
    logic [LVL_DEPTH-1:0]  lvl_cleared;

    assign is_add   = (kind == KIND_ADD_ACTIVE) || (kind == KIND_ADD_EXPIRED);
    assign is_pick  = (kind == KIND_PICK);
    assign in_range = (int'(priority_req) < NUM_LEVELS) && (int'(thread_id) < MAX_THREADS);
    assign add_bank = (kind == KIND_ADD_EXPIRED) ? ~active_bank_reg : active_bank_reg;

    assign both_empty = (act_total_reg == '0) && (exp_total_reg == '0);
    assign do_swap    = (act_total_reg == '0) && (exp_total_reg != '0);
    assign pk_bank    = active_bank_reg ^ do_swap;

    // two-level lookup: highest group, then highest level inside it
    assign pk_grp  = top_bit8(8'(grp_bits_reg[pk_bank]));
    assign pk_byte = lvl_bits_reg[pk_bank][LVL_W'({pk_grp, 3'b000}) +: 8];
    assign pk_bit  = top_bit8(pk_byte);
    assign pk_lvl  = {pk_grp, pk_bit};

    assign add_addr = {add_bank, priority_req[LVL_W-1:0]};
    assign pk_addr  = {pk_bank, LVL_W'(pk_lvl)};
    assign op_addr  = {op_bank_reg, op_lvl_reg[LVL_W-1:0]};

    assign op_li       = op_lvl_reg[LVL_W-1:0];
    assign op_base     = op_li & ~LVL_W'(7);
    assign add_empty   = ~lvl_bits_reg[op_bank_reg][op_li];
    assign last_one    = (head_rdata == tail_rdata);
    assign lvl_cleared = lvl_bits_reg[op_bank_reg] & ~(LVL_DEPTH'(1) << op_li);
    assign grp_empty   = (lvl_cleared[op_base +: 8] == 8'd0);

    assign sts.add_ok   = is_add && in_range && !queued_reg[thread_id[IDXW-1:0]];
    assign sts.pick_req = is_pick;
    assign sts.multi    = !op_idle_reg && !last_one;

    assign head_we    = (cmd.add_exec && add_empty) || cmd.pop_exec;
    assign head_wdata = cmd.pop_exec ? next_rdata : op_tid_reg;
    assign next_we    = cmd.add_exec && !add_empty;
    assign tail_raddr = is_pick ? pk_addr : add_addr;

    prbq_ram #(
        .WIDTH (IDXW),
        .DEPTH (2 * LVL_DEPTH)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (op_addr),
        .wdata (head_wdata),
        .raddr (pk_addr),
        .rdata (head_rdata)
    );

    prbq_ram #(
        .WIDTH (IDXW),
        .DEPTH (2 * LVL_DEPTH)
    ) u_tail_ram (
        .clk   (clk),
        .we    (cmd.add_exec),
        .waddr (op_addr),
        .wdata (op_tid_reg),
        .raddr (tail_raddr),
        .rdata (tail_rdata)
    );

    // successor of each queued thread
    prbq_ram #(
        .WIDTH (IDXW),
        .DEPTH (TID_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (tail_rdata),
        .wdata (op_tid_reg),
        .raddr (head_rdata),
        .rdata (next_rdata)
    );

    always_comb
    begin
        active_bank_next = active_bank_reg;
        act_total_next   = act_total_reg;
        exp_total_next   = exp_total_reg;
        queued_next      = queued_reg;
        grp_bits_next    = grp_bits_reg;
        lvl_bits_next    = lvl_bits_reg;

        if (cmd.add_exec)
        begin
            lvl_bits_next[op_bank_reg] = lvl_bits_reg[op_bank_reg] | (LVL_DEPTH'(1) << op_li);
            grp_bits_next[op_bank_reg] = grp_bits_reg[op_bank_reg]
                                         | (NUM_GROUPS'(1) << (op_li >> 3));
            queued_next[op_tid_reg]    = 1'b1;
            if (op_bank_reg == active_bank_reg)
            begin
                act_total_next = act_total_reg + CNT_W'(1);
            end
            else
            begin
                exp_total_next = exp_total_reg + CNT_W'(1);
            end
        end

        if (cmd.pick_exec && !op_idle_reg)
        begin
            if (last_one)
            begin
                lvl_bits_next[op_bank_reg] = lvl_cleared;
                if (grp_empty)
                begin
                    grp_bits_next[op_bank_reg] = grp_bits_reg[op_bank_reg]
                                                 & ~(NUM_GROUPS'(1) << (op_li >> 3));
                end
            end
            queued_next[head_rdata] = 1'b0;
            if (op_swap_reg)
            begin
                active_bank_next = ~active_bank_reg;
                act_total_next   = exp_total_reg - CNT_W'(1);
                exp_total_next   = '0;
            end
            else
            begin
                act_total_next = act_total_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bank_reg <= 1'b0;
            act_total_reg   <= '0;
            exp_total_reg   <= '0;
            queued_reg      <= '0;
            grp_bits_reg    <= '{default: '0};
            lvl_bits_reg    <= '{default: '0};
            strobe_reg      <= 1'b0;
        end
        else
        begin
            active_bank_reg <= active_bank_next;
            act_total_reg   <= act_total_next;
            exp_total_reg   <= exp_total_next;
            queued_reg      <= queued_next;
            grp_bits_reg    <= grp_bits_next;
            lvl_bits_reg    <= lvl_bits_next;
            strobe_reg      <= cmd.pick_exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_bank_reg <= is_pick ? pk_bank : add_bank;
            op_lvl_reg  <= is_pick ? pk_lvl : priority_req;
            op_tid_reg  <= thread_id[IDXW-1:0];
            op_idle_reg <= both_empty;
            op_swap_reg <= do_swap;
        end
        if (cmd.pick_exec)
        begin
            picked_thread_reg   <= op_idle_reg ? '0 : THREAD_W'(head_rdata);
            picked_priority_reg <= op_idle_reg ? '0 : op_lvl_reg;
            idle_reg            <= op_idle_reg;
            swapped_reg         <= op_swap_reg;
        end
    end

    assign strobe          = strobe_reg;
    assign picked_thread   = picked_thread_reg;
    assign picked_priority = picked_priority_reg;
    assign idle            = idle_reg;
    assign swapped         = swapped_reg;

endmodule

`default_nettype wire

@@ sv/prbq_checker.sv @@
// ----------------------------------------------------------------------------
// prbq_assert_checker
// port-level timing and result checks, bound to the ready queue top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module prbq_assert_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [prbq_pkg::KIND_W-1:0]   kind,
    input  logic                          strobe,
    input  logic [prbq_pkg::THREAD_W-1:0] picked_thread,
    input  logic [prbq_pkg::PRIO_W-1:0]   picked_priority,
    input  logic                          idle,
    input  logic                          swapped
);
    import prbq_pkg::*;

    logic pick_beat;

    assign pick_beat = start && !busy && (kind == KIND_PICK);

    // every result beat belongs to an earlier pick, via the pick state and strobe
    `ASSERT_IMPL(a_result_from_pick, strobe, $past(pick_beat, 2), "result without a pick")

    // a pick always holds off the next command
    `ASSERT_NEXT(a_pick_busy, pick_beat, busy, "pick accepted without going busy")

    // no command stays busy longer than a pick step followed by a pop step
    `ASSERT_NEXT(a_busy_bound, busy && $past(busy), !busy, "busy longer than two cycles")

    `ASSERT_IMPL(a_idle_result, strobe && idle,
                 (picked_thread == '0) && (picked_priority == '0) && !swapped,
                 "idle result carries a thread")

endmodule

bind priority_bitmap_ready_queue_core prbq_assert_checker u_prbq_checker (.*);

`default_nettype wire
